FILE: src/crfi_pkg.sv
// Shared types, register codes and the intensity key function.
package crfi_pkg;

  localparam int PIX_W = 24;
  localparam int KEY_W = 8;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [KEY_W-1:0] key_t;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;
  localparam logic [1:0] REG_RANK   = 2'd3;

  localparam int CFG_W = 13;

  // (b+g+r)/3 as a multiply by 683/2048, exact for sums up to 765
  function automatic key_t key_of(input pix_t p);
    logic [9:0]  s;
    logic [19:0] m;
    s = {2'b00, p[7:0]} + {2'b00, p[15:8]} + {2'b00, p[23:16]};
    m = {10'd0, s} * 20'd683;
    return m[18:11];
  endfunction

endpackage

FILE: src/crfi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module crfi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/color_rank_filter_by_intensity.sv
// Top level of the streaming color rank-order filter ranked by intensity.
//
// Channel  Dir  Ports                 Content
// in_      in   tvalid/tready/tdata   tdata[23:0] = blue, green, red; tuser = mode (1 = flush)
// out_     out  tvalid/tready/tdata   tdata[23:0] = blue, green, red; tlast = frame_end
// cfg_     in   we/index/data         image_width, image_height, window_radius, rank_index
//
// One item per clock when the output is taken. An item goes through five
// register stages: line store read (one RAM port, one column entry per
// item), window shift, pairwise key compare, rank count, output register.
// The pipeline moves as a whole; it holds only while a result waits in the
// output register and out_tready is low. Back-to-back items on the same
// line store column are forwarded from the last write.
// Reset (rst_n low, synchronous) clears counters and valid bits and sets the
// configuration defaults; line store, window and data registers stay undefined until written.
module color_rank_filter_by_intensity
  import crfi_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // blue [7:0], green [15:8], red [23:16]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // blue [7:0], green [15:8], red [23:16]
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int MS  = 2 * MAX_RADIUS + 1;  // window side
  localparam int NW  = MS * MS;             // window entries
  localparam int LS  = 2 * MAX_RADIUS;      // rows held per column
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int HW  = 13;
  localparam int LW  = CW + RW + 1;         // lag width
  localparam int PW  = LW + 1;              // pending count width
  localparam int CNW = $clog2(NW + 1);

  // configuration registers
  logic [10:0] cfg_width_r;
  logic [12:0] cfg_height_r;
  logic [1:0]  cfg_radius_r;
  logic [5:0]  cfg_rank_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= 11'd1024;
      cfg_height_r <= 13'd768;
      cfg_radius_r <= 2'd1;
      cfg_rank_r   <= 6'd4;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  cfg_width_r  <= cfg_data[10:0];
        REG_HEIGHT: cfg_height_r <= cfg_data[12:0];
        REG_RADIUS: cfg_radius_r <= cfg_data[1:0];
        REG_RANK:   cfg_rank_r   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // effective sizes: clamp out-of-range register values
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [RW-1:0] r_eff;
  logic [LW-1:0] lag;
  logic [5:0]    want;
  logic [7:0]    nmax;

  always_comb begin
    if (cfg_width_r == 11'd0) begin
      w_eff = CW'(1);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(cfg_width_r);
    end
    if (cfg_height_r == 13'd0) begin
      h_eff = 13'd1;
    end else if (cfg_height_r > 13'd4096) begin
      h_eff = 13'd4096;
    end else begin
      h_eff = cfg_height_r;
    end
    if (32'(cfg_radius_r) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(cfg_radius_r);
    end
    lag  = LW'(r_eff) * LW'(w_eff) + LW'(r_eff);
    nmax = 8'(4 * 8'(r_eff) * 8'(r_eff) + 4 * 8'(r_eff));
    want = ({2'b00, cfg_rank_r} > nmax) ? 6'(nmax) : cfg_rank_r;
  end

  // pipeline advance: hold only while a result waits unclaimed
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // position counters and pending count
  logic [CW-1:0] ic_r, oc_r;
  logic [HW-1:0] ir_r, or_r;
  logic [PW-1:0] pend_r;

  logic          acc, mode, shifts, emit;
  logic [CW:0]   fcol;
  logic [CW-1:0] col;
  logic          inner, fend;

  always_comb begin
    acc  = in_tvalid && adv;
    mode = in_tuser;
    // column of the flush phantom: r positions after the next output
    fcol = {1'b0, oc_r} + (CW+1)'(r_eff);
    for (int k = 0; k <= MAX_RADIUS; k++) begin
      if (fcol >= {1'b0, w_eff}) begin
        fcol = fcol - {1'b0, w_eff};
      end
    end
    col    = mode ? fcol[CW-1:0] : ic_r;
    shifts = !mode || (pend_r != '0);
    emit   = mode ? (pend_r != '0) : ((pend_r + PW'(1)) > PW'(lag));
    inner  = (oc_r >= CW'(r_eff)) && ((oc_r + CW'(r_eff)) < w_eff) &&
             (or_r >= HW'(r_eff)) && ((or_r + HW'(r_eff)) < h_eff);
    fend   = ((oc_r + CW'(1)) >= w_eff) && ((or_r + HW'(1)) >= h_eff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r   <= '0;
      ir_r   <= '0;
      oc_r   <= '0;
      or_r   <= '0;
      pend_r <= '0;
    end else if (acc) begin
      if (!mode) begin
        // advance input position, wrap the column at the line end and the row at the frame end
        if ((ic_r + CW'(1)) >= w_eff) begin
          ic_r <= '0;
          ir_r <= ((ir_r + HW'(1)) >= h_eff) ? '0 : ir_r + HW'(1);
        end else begin
          ic_r <= ic_r + CW'(1);
        end
        pend_r <= pend_r + PW'(1) - PW'(emit);
      end else begin
        pend_r <= pend_r - PW'(emit);
      end
      if (emit) begin
        if ((oc_r + CW'(1)) >= w_eff) begin
          oc_r <= '0;
          or_r <= ((or_r + HW'(1)) >= h_eff) ? '0 : or_r + HW'(1);
        end else begin
          oc_r <= oc_r + CW'(1);
        end
      end
    end
  end

  // stage 1: line store read in flight
  logic          s1_v_r, s1_emit_r, s1_inner_r, s1_fend_r;
  logic [AW-1:0] s1_col_r;
  pix_t          s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= acc && shifts;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_emit_r  <= emit;
      s1_inner_r <= inner;
      s1_fend_r  <= fend;
      s1_col_r   <= col[AW-1:0];
      s1_pix_r   <= mode ? '0 : in_tdata;
    end
  end

  logic [LS*PIX_W-1:0] ram_rdata, rd, wdata;
  logic                lw_v_r;
  logic [AW-1:0]       lw_a_r;
  logic [LS*PIX_W-1:0] lw_d_r;
  pix_t                newcol [MS];

  crfi_ram #(
    .WIDTH(LS * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk  (clk),
    .we   (adv && s1_v_r),
    .waddr(s1_col_r),
    .wdata(wdata),
    .re   (adv),
    .raddr(col[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    // forward the write of the previous item to the same column
    rd = (lw_v_r && (lw_a_r == s1_col_r)) ? lw_d_r : ram_rdata;
    newcol[0] = s1_pix_r;
    for (int k = 1; k < MS; k++) begin
      newcol[k] = rd[(k-1)*PIX_W +: PIX_W];
    end
    wdata[PIX_W-1:0] = s1_pix_r;
    for (int k = 1; k < LS; k++) begin
      wdata[k*PIX_W +: PIX_W] = rd[(k-1)*PIX_W +: PIX_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_v_r <= 1'b0;
    end else if (adv) begin
      lw_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lw_a_r <= s1_col_r;
      lw_d_r <= wdata;
    end
  end

  // window registers, index dy*MS + dx (dx = column age, dy = row age)
  pix_t win_r [NW];
  key_t key_r [NW];

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      for (int dy = 0; dy < MS; dy++) begin
        for (int dx = MS - 1; dx > 0; dx--) begin
          win_r[dy*MS+dx] <= win_r[dy*MS+dx-1];
          key_r[dy*MS+dx] <= key_r[dy*MS+dx-1];
        end
        win_r[dy*MS] <= newcol[dy];
        key_r[dy*MS] <= key_of(newcol[dy]);
      end
    end
  end

  // stage 2: window holds the item's view
  logic s2_v_r, s2_inner_r, s2_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_inner_r <= s1_inner_r;
      s2_fend_r  <= s1_fend_r;
    end
  end

  // pairwise compare: j ranks below i on a smaller key, or an equal key
  // with an earlier raster place (larger linear index)
  logic [NW-1:0] incl;
  logic [NW-1:0] lt [NW];
  pix_t          pass;

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      incl[i] = ((i % MS) <= 2 * int'(r_eff)) && ((i / MS) <= 2 * int'(r_eff));
    end
    for (int i = 0; i < NW; i++) begin
      for (int j = 0; j < NW; j++) begin
        lt[i][j] = (j != i) && incl[j] &&
                   ((key_r[j] < key_r[i]) || ((key_r[j] == key_r[i]) && (j > i)));
      end
    end
    pass = win_r[0];
    for (int q = 0; q <= MAX_RADIUS; q++) begin
      if (RW'(q) == r_eff) begin
        pass = win_r[q*MS+q];
      end
    end
  end

  // stage 3: compare matrix registered
  logic          s3_v_r, s3_inner_r, s3_fend_r;
  logic [NW-1:0] s3_lt_r [NW];
  logic [NW-1:0] s3_incl_r;
  pix_t          s3_val_r [NW];
  pix_t          s3_pass_r;
  logic [5:0]    s3_want_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (adv) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_inner_r <= s2_inner_r;
      s3_fend_r  <= s2_fend_r;
      s3_lt_r    <= lt;
      s3_incl_r  <= incl;
      s3_val_r   <= win_r;
      s3_pass_r  <= pass;
      s3_want_r  <= want;
    end
  end

  // rank count per entry; exactly one included entry hits the wanted rank
  logic [NW-1:0] hit;

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      hit[i] = s3_incl_r[i] &&
               (CNW'($countones(s3_lt_r[i])) == CNW'(s3_want_r));
    end
  end

  // stage 4: hit vector registered
  logic          s4_v_r, s4_inner_r, s4_fend_r;
  logic [NW-1:0] s4_hit_r;
  pix_t          s4_val_r [NW];
  pix_t          s4_pass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_inner_r <= s3_inner_r;
      s4_fend_r  <= s3_fend_r;
      s4_hit_r   <= hit;
      s4_val_r   <= s3_val_r;
      s4_pass_r  <= s3_pass_r;
    end
  end

  pix_t sel;

  always_comb begin
    sel = '0;
    for (int i = 0; i < NW; i++) begin
      sel = sel | (s4_hit_r[i] ? s4_val_r[i] : '0);
    end
  end

  // output register
  logic out_v_r, out_last_r;
  pix_t out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_d_r    <= s4_inner_r ? sel : s4_pass_r;
      out_last_r <= s4_fend_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: tb/tb.sv
// Self-checking bench for the streaming color rank-order filter.
module tb;
  import crfi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX = 1024;
  localparam int RAD_MAX  = 3;
  localparam int SIDE_MAX = 2 * RAD_MAX + 1;
  localparam int HGT_MAX  = 4096;
  localparam int DRAIN_CYCLES = 20;  // five pipeline stages, with margin

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef struct {
    pix_t pix;
    logic last;
  } out_pix_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [23:0]      in_tdata = '0;   // blue [7:0], green [15:8], red [23:16]
  logic             in_tuser = 1'b0; // mode
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [23:0]      out_tdata;       // blue [7:0], green [15:8], red [23:16]
  logic             out_tlast;       // frame_end
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;

  color_rank_filter_by_intensity DUT (.*);

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter predictor: line store, window, raster counters and register copies
  // ---------------------------------------------------------------------------
  pix_t        lstore [LINE_MAX][2*RAD_MAX];
  pix_t        wpix   [SIDE_MAX][SIDE_MAX];  // [column age][row age]
  int unsigned icol, irow, ocol, orow, npend;
  int unsigned reg_w = 1024, reg_h = 768, reg_r = 1, reg_rank = 4;

  out_pix_t    expected_pix[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          frames_done = 0;

  function automatic int unsigned eff_w();
    return (reg_w < 1) ? 1 : (reg_w > LINE_MAX) ? LINE_MAX : reg_w;
  endfunction

  function automatic int unsigned eff_h();
    return (reg_h < 1) ? 1 : (reg_h > HGT_MAX) ? HGT_MAX : reg_h;
  endfunction

  function automatic int unsigned intensity(pix_t p);
    return (int'(p[7:0]) + int'(p[15:8]) + int'(p[23:16])) / 3;
  endfunction

  // Shift a pixel into the window and push it down its line store column.
  function automatic void push_column(int unsigned col, pix_t pix);
    int unsigned c;
    c = col % LINE_MAX;
    for (int dx = SIDE_MAX - 1; dx > 0; dx--)
      for (int k = 0; k < SIDE_MAX; k++) wpix[dx][k] = wpix[dx-1][k];
    wpix[0][0] = pix;
    for (int k = 1; k < SIDE_MAX; k++) wpix[0][k] = lstore[c][k-1];
    for (int k = 2*RAD_MAX - 1; k > 0; k--) lstore[c][k] = lstore[c][k-1];
    lstore[c][0] = pix;
  endfunction

  // Pick the pixel at the chosen rank; equal keys keep raster order.
  function automatic pix_t ranked_pixel(int unsigned r);
    pix_t        vals[SIDE_MAX*SIDE_MAX];
    int unsigned keys[SIDE_MAX*SIDE_MAX];
    int unsigned n, want, pos;
    n = 0;
    for (int a = -int'(r); a <= int'(r); a++)
      for (int b = -int'(r); b <= int'(r); b++) begin
        vals[n] = wpix[int'(r) - b][int'(r) - a];
        keys[n] = intensity(vals[n]);
        n++;
      end
    want = (reg_rank > n - 1) ? n - 1 : reg_rank;
    for (int i = 0; i < n; i++) begin
      pos = 0;
      for (int j = 0; j < n; j++)
        if (keys[j] < keys[i] || (keys[j] == keys[i] && j < i)) pos++;
      if (pos == want) return vals[i];
    end
    return vals[0];
  endfunction

  // Advance the predictor by one accepted item; queue the pixel it releases.
  function automatic void predict_item(logic mode, pix_t pix);
    int unsigned w, h, r, lag;
    logic        inner;
    out_pix_t    o;
    w = eff_w();
    h = eff_h();
    r = (reg_r > RAD_MAX) ? RAD_MAX : reg_r;
    lag = r * w + r;
    if (mode == MODE_PIXEL) begin
      push_column(icol, pix);
      icol++;
      if (icol >= w) begin
        icol = 0;
        irow++;
        if (irow >= h) irow = 0;
      end
      npend++;
      if (npend <= lag) return;
    end else begin
      if (npend == 0) return;
      push_column((ocol + r) % w, '0);
    end
    npend--;
    inner = (ocol >= r) && (ocol + r < w) && (orow >= r) && (orow + r < h);
    o.pix  = inner ? ranked_pixel(r) : wpix[r][r];
    o.last = (ocol + 1 >= w) && (orow + 1 >= h);
    if (o.last) frames_done++;
    expected_pix = {expected_pix, o};
    ocol++;
    if (ocol >= w) begin
      ocol = 0;
      orow++;
      if (orow >= h) orow = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result check: compare each taken pixel with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_pix_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_pix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected pixel %h last %b", out_tdata, out_tlast);
      end else begin
        e = expected_pix.pop_front();
        if (out_tdata !== e.pix || out_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: pixel %0d: expected bgr %h last %b, got bgr %h last %b",
                     results_seen, e.pix, e.last, out_tdata, out_tlast);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall level changes at random intervals, including none
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(50, 300);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
    end
    stall_left--;
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  int burst_left = 1;

  // Call at a falling edge; returns at a falling edge once the item is taken.
  task automatic send_item(logic mode, pix_t pix);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    predict_item(mode, pix);
    items_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      if ($urandom_range(0, 2) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  // Drain the tail with flush items until nothing is held back.
  task automatic drain_tail();
    while (npend > 0) send_item(MODE_FLUSH, '0);
  endtask

  // Wait for every expected pixel, then let the pipeline settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_pix.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_WIDTH:  reg_w    = value & 'h7FF;
      REG_HEIGHT: reg_h    = value & 'h1FFF;
      REG_RADIUS: reg_r    = value & 'h3;
      REG_RANK:   reg_rank = value & 'h3F;
      default: ;
    endcase
  endtask

  task automatic set_filter(int unsigned w, int unsigned h, int unsigned r,
                            int unsigned rank);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
    write_reg(REG_RANK, rank);
  endtask

  // Mix of fully random colors, a small palette that forces equal keys,
  // and gray levels.
  function automatic pix_t some_pixel();
    logic [7:0] g;
    case ($urandom_range(0, 3))
      0, 1: return pix_t'($urandom);
      2: begin
        case ($urandom_range(0, 5))
          0: return 24'h000000;
          1: return 24'hFFFFFF;
          2: return 24'h030000;
          3: return 24'h000300;
          4: return 24'h000003;
          default: return 24'h010101;
        endcase
      end
      default: begin
        g = 8'($urandom_range(0, 255));
        return {g, g, g};
      end
    endcase
  endfunction

  task automatic send_frame(int unsigned n_pix, int flush_pct);
    for (int i = 0; i < n_pix; i++) begin
      if ($urandom_range(0, 99) < flush_pct) send_item(MODE_FLUSH, '0);
      send_item(MODE_PIXEL, some_pixel());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // 5x5 frame, 3x3 window: extreme colors at the corners, equal-key runs.
  task automatic test_directed();
    pix_t frame[25];
    set_filter(5, 5, 1, 4);
    send_item(MODE_FLUSH, '0);  // nothing pending: no pixel out
    foreach (frame[i]) frame[i] = some_pixel();
    frame[0]  = 24'h000000;
    frame[4]  = 24'hFFFFFF;
    frame[20] = 24'hFFFFFF;
    frame[24] = 24'h000000;
    frame[6]  = 24'h030000;
    frame[7]  = 24'h000300;
    frame[8]  = 24'h000003;
    frame[11] = 24'h010101;
    frame[12] = 24'h020001;
    frame[13] = 24'h00FF00;
    foreach (frame[i]) send_item(MODE_PIXEL, frame[i]);
    drain_tail();
    wait_idle();
  endtask

  // Single-pixel frames with no window; clamp of zero width and height.
  task automatic test_unit_frame();
    set_filter(0, 0, 0, 0);
    for (int i = 0; i < 10; i++) send_item(MODE_PIXEL, some_pixel());
    send_item(MODE_FLUSH, '0);
    wait_idle();
  endtask

  // Largest window, lowest rank and clamped highest rank.
  task automatic test_rank_extremes();
    set_filter(7, 7, 3, 63);
    send_frame(49, 0);
    drain_tail();
    wait_idle();
    set_filter(9, 8, 3, 0);
    send_frame(72, 0);
    drain_tail();
    wait_idle();
    set_filter(4, 4, 1, 8);
    send_frame(16, 0);
    drain_tail();
    wait_idle();
  endtask

  // Random small frames that hold at least one full window; some stray
  // flushes mid-frame.
  task automatic test_random_frames();
    int unsigned w, h, r, start;
    start = items_sent;
    while (items_sent - start < 720) begin
      r = $urandom_range(0, 3);
      w = $urandom_range(1, 14);
      h = $urandom_range(1, 10);
      if (w < 2*r + 1) w = 2*r + 1;
      if (h < 2*r + 1) h = 2*r + 1;
      set_filter(w, h, r, $urandom_range(0, 63));
      for (int f = $urandom_range(1, 3); f > 0; f--)
        send_frame(w * h, ($urandom_range(0, 3) == 0) ? 5 : 0);
      drain_tail();
      wait_idle();
    end
  endtask

  // Over-range width and height clamp to the maxima; the run ends mid-frame.
  task automatic test_size_limits();
    set_filter(2047, 8191, 0, 5);
    send_frame(30, 0);
    drain_tail();
    wait_idle();
  endtask

  initial begin
    for (int c = 0; c < LINE_MAX; c++)
      for (int k = 0; k < 2*RAD_MAX; k++) lstore[c][k] = '0;
    for (int a = 0; a < SIDE_MAX; a++)
      for (int b = 0; b < SIDE_MAX; b++) wpix[a][b] = '0;
    icol = 0; irow = 0; ocol = 0; orow = 0; npend = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_unit_frame();
    test_rank_extremes();
    test_random_frames();
    test_size_limits();

    $display("Sent %0d items (pixels and flushes), checked %0d output pixels,",
             items_sent, results_seen);
    $display("%0d complete frames over radii 0..3 and clamped sizes and ranks.",
             frames_done);
    if (mismatches == 0 && expected_pix.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d pixels never seen", mismatches,
               expected_pix.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("Timeout waiting for the filter");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
